### hdl/sjt_pkg.sv
package sjt_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int TABLE_ADDR_W = 12;
    localparam int COUNT_W      = 13;
    localparam int CHAR_W       = 16;
    localparam int BYTE_W       = 8;
    localparam int KIND_W       = 2;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_RAW1  = 3'd1;
    localparam logic [2:0] OP_RAW2  = 3'd2;
    localparam logic [2:0] OP_MAP   = 3'd3;
    localparam logic [2:0] OP_END   = 3'd4;

    localparam logic [KIND_W-1:0] KIND_RAW = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MAP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    localparam logic [BYTE_W-1:0] LEAD_A_LO   = 8'h81;
    localparam logic [BYTE_W-1:0] LEAD_A_END  = 8'hA0;
    localparam logic [BYTE_W-1:0] LEAD_B_LO   = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_B_END  = 8'hFD;
    localparam logic [BYTE_W-1:0] REMAP_LO    = 8'hF0;
    localparam logic [BYTE_W-1:0] REMAP_HI    = 8'hFC;
    localparam logic [BYTE_W-1:0] TRAIL_LO    = 8'h40;
    localparam logic [BYTE_W-1:0] TRAIL_HI    = 8'hFC;
    localparam logic [BYTE_W-1:0] TRAIL_GAP   = 8'h7F;
    localparam logic [BYTE_W-1:0] TRAIL_LO_HI = 8'h41;
    localparam logic [TABLE_ADDR_W-1:0] ROW_STRIDE = 12'd188;

    localparam int APB_ADDR_W = 3;
    localparam logic REG_TABLE_COUNT = 1'b0;

    typedef struct packed {
        logic [2:0]              op;
        logic [CHAR_W-1:0]       val;
        logic [BYTE_W-1:0]       trail;
        logic [TABLE_ADDR_W-1:0] addr;
        logic                    last;
        logic                    any;
    } cmd_t;

endpackage

### hdl/sjt_ram.sv
module sjt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/sjt_front.sv
module sjt_front import sjt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_req_type,
    input  logic [BYTE_W-1:0]       s_data_byte,
    input  logic                    s_last_byte,
    input  logic                    s_zero_ends,
    input  logic [TABLE_ADDR_W-1:0] s_table_addr,
    input  logic [CHAR_W-1:0]       s_table_char,
    input  logic [COUNT_W-1:0]      table_count,
    input  logic                    q_full,
    output logic                    push_valid,
    output cmd_t                    push_cmd
);

    logic [BYTE_W-1:0] held_lead_reg, held_lead_next;
    logic              lead_pending_reg, lead_pending_next;
    logic              mapped_seen_reg, mapped_seen_next;
    logic              skipping_reg, skipping_next;

    logic                    accept;
    logic                    is_lead;
    logic                    pair_ok;
    logic                    map_ok;
    logic [BYTE_W-1:0]       trail_off;
    logic [TABLE_ADDR_W-1:0] pair_idx;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign is_lead = (s_data_byte >= LEAD_A_LO && s_data_byte < LEAD_A_END)
                  || (s_data_byte >= LEAD_B_LO && s_data_byte < LEAD_B_END);

    assign pair_ok = held_lead_reg >= REMAP_LO && held_lead_reg <= REMAP_HI
                  && s_data_byte >= TRAIL_LO && s_data_byte <= TRAIL_HI
                  && s_data_byte != TRAIL_GAP;

    assign trail_off = (s_data_byte < TRAIL_GAP) ? s_data_byte - TRAIL_LO
                                                 : s_data_byte - TRAIL_LO_HI;
    assign pair_idx  = TABLE_ADDR_W'(held_lead_reg[3:0]) * ROW_STRIDE
                     + TABLE_ADDR_W'(trail_off);
    assign map_ok    = pair_ok && ({1'b0, pair_idx} < table_count);

    always_comb begin
        logic mapped_now;
        mapped_now        = mapped_seen_reg;
        held_lead_next    = held_lead_reg;
        lead_pending_next = lead_pending_reg;
        mapped_seen_next  = mapped_seen_reg;
        skipping_next     = skipping_reg;
        push_valid        = 1'b0;
        push_cmd          = '0;
        if (accept) begin
            if (s_req_type == REQ_WRITE) begin
                push_cmd.op   = OP_WRITE;
                push_cmd.val  = s_table_char;
                push_cmd.addr = s_table_addr;
                push_valid    = 32'(s_table_addr) < TABLE_DEPTH;
            end else if (skipping_reg) begin
                if (s_last_byte) begin
                    skipping_next = 1'b0;
                end
            end else if (s_data_byte == '0 && s_zero_ends) begin
                push_valid        = 1'b1;
                push_cmd.op       = OP_END;
                push_cmd.last     = 1'b1;
                push_cmd.any      = mapped_seen_reg;
                held_lead_next    = '0;
                lead_pending_next = 1'b0;
                mapped_seen_next  = 1'b0;
                skipping_next     = !s_last_byte;
            end else if (lead_pending_reg) begin
                push_valid        = 1'b1;
                lead_pending_next = 1'b0;
                held_lead_next    = '0;
                push_cmd.val      = {8'h00, held_lead_reg};
                push_cmd.trail    = s_data_byte;
                push_cmd.addr     = pair_idx;
                if (map_ok) begin
                    push_cmd.op = OP_MAP;
                    mapped_now  = 1'b1;
                end else begin
                    push_cmd.op = OP_RAW2;
                end
                push_cmd.last    = s_last_byte;
                push_cmd.any     = s_last_byte && mapped_now;
                mapped_seen_next = !s_last_byte && mapped_now;
            end else if (is_lead && !s_last_byte) begin
                held_lead_next    = s_data_byte;
                lead_pending_next = 1'b1;
            end else begin
                push_valid       = 1'b1;
                push_cmd.op      = OP_RAW1;
                push_cmd.val     = {8'h00, s_data_byte};
                push_cmd.last    = s_last_byte;
                push_cmd.any     = s_last_byte && mapped_seen_reg;
                mapped_seen_next = !s_last_byte && mapped_seen_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_lead_reg    <= '0;
            lead_pending_reg <= 1'b0;
            mapped_seen_reg  <= 1'b0;
            skipping_reg     <= 1'b0;
        end else begin
            held_lead_reg    <= held_lead_next;
            lead_pending_reg <= lead_pending_next;
            mapped_seen_reg  <= mapped_seen_next;
            skipping_reg     <= skipping_next;
        end
    end

endmodule

### hdl/sjt_fifo.sv
module sjt_fifo import sjt_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = count_reg == CW'(DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_cmd   = mem_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### hdl/sjt_back.sv
module sjt_back import sjt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  cmd_t              q_cmd,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_out_kind,
    output logic [CHAR_W-1:0] m_out_value,
    output logic              m_out_last,
    output logic              m_any_mapped
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_phase_reg, s1_phase_next;
    cmd_t              s1_cmd_reg, s1_cmd_next;
    logic              m_valid_reg, m_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [CHAR_W-1:0] value_reg, value_next;
    logic              last_reg, last_next;
    logic              any_reg, any_next;

    logic              out_free;
    logic              s1_emit;
    logic              s1_done;
    logic              s1_open;
    logic              is_write;
    logic              load_s1;
    logic              ram_we;
    logic [CHAR_W-1:0] ram_rdata;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_emit  = s1_valid_reg && out_free;
    assign s1_done  = s1_emit && (s1_cmd_reg.op != OP_RAW2 || s1_phase_reg);
    assign s1_open  = !s1_valid_reg || s1_done;
    assign is_write = q_cmd.op == OP_WRITE;
    assign q_pop    = q_valid && (is_write || s1_open);
    assign load_s1  = q_pop && !is_write;
    assign ram_we   = q_pop && is_write;

    sjt_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(AW'(q_cmd.addr)),
        .wdata(q_cmd.val),
        .re   (load_s1),
        .raddr(AW'(q_cmd.addr)),
        .rdata(ram_rdata)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_phase_next = s1_phase_reg;
        s1_cmd_next   = s1_cmd_reg;
        if (load_s1) begin
            s1_valid_next = 1'b1;
            s1_phase_next = 1'b0;
            s1_cmd_next   = q_cmd;
        end else if (s1_done) begin
            s1_valid_next = 1'b0;
        end else if (s1_emit) begin
            s1_phase_next = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        value_next   = value_reg;
        last_next    = last_reg;
        any_next     = any_reg;
        if (s1_emit) begin
            m_valid_next = 1'b1;
            last_next    = s1_cmd_reg.last;
            any_next     = s1_cmd_reg.any;
            case (s1_cmd_reg.op)
                OP_MAP: begin
                    kind_next  = KIND_MAP;
                    value_next = ram_rdata;
                end
                OP_END: begin
                    kind_next  = KIND_END;
                    value_next = '0;
                end
                OP_RAW2: begin
                    kind_next = KIND_RAW;
                    if (s1_phase_reg) begin
                        value_next = {8'h00, s1_cmd_reg.trail};
                    end else begin
                        value_next = s1_cmd_reg.val;
                        last_next  = 1'b0;
                        any_next   = 1'b0;
                    end
                end
                default: begin
                    kind_next  = KIND_RAW;
                    value_next = s1_cmd_reg.val;
                end
            endcase
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_phase_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s1_phase_reg <= s1_phase_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_cmd_reg <= s1_cmd_next;
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
        any_reg    <= any_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_kind   = kind_reg;
    assign m_out_value  = value_reg;
    assign m_out_last   = last_reg;
    assign m_any_mapped = any_reg;

    a_raw2_second_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_emit && s1_cmd_reg.op == OP_RAW2 && !s1_phase_reg
        |=> s1_valid_reg && s1_phase_reg)
        else $error("second byte of an unmapped pair was lost");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && kind_reg == KIND_END |-> last_reg)
        else $error("end beat without last flag");

    a_any_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && any_reg |-> last_reg)
        else $error("any_mapped set on a beat that is not last");

    a_no_read_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_done |-> !load_s1)
        else $error("table read issued while a lookup is still held");

endmodule

### hdl/sjis_tunnel_char_remapper.sv
// Channel   | Ports                                   | Beat
// ----------+-----------------------------------------+-------------------------------
// input     | s_valid/s_ready, s_req_type ...         | one byte or one table write
// result    | m_valid/m_ready, m_out_kind ...         | one raw byte, char or end mark
// config    | psel/penable/pwrite/paddr/pwdata/prdata | table_count at address 0
//
// One input beat is taken per cycle while the command queue has room.
// A mapped pair gives its result through the command queue and the
// registered table read; an unmapped pair gives two raw results, lead byte first.
// Reset is synchronous on aresetn; the table contents are not cleared.
// The queue lets the input keep flowing while the result side is stalled.
module sjis_tunnel_char_remapper import sjt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_req_type,
    input  logic [BYTE_W-1:0]       s_data_byte,
    input  logic                    s_last_byte,
    input  logic                    s_zero_ends,
    input  logic [TABLE_ADDR_W-1:0] s_table_addr,
    input  logic [CHAR_W-1:0]       s_table_char,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [KIND_W-1:0]       m_out_kind,
    output logic [CHAR_W-1:0]       m_out_value,
    output logic                    m_out_last,
    output logic                    m_any_mapped
);

    logic [COUNT_W-1:0] table_count_reg, table_count_next;
    logic               cfg_write;
    logic               q_full;
    logic               push_valid;
    cmd_t               push_cmd;
    logic               pop;
    logic               pop_valid;
    cmd_t               pop_cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        table_count_next = table_count_reg;
        if (cfg_write && paddr[2] == REG_TABLE_COUNT) begin
            table_count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_count_reg <= '0;
        end else begin
            table_count_reg <= table_count_next;
        end
    end

    assign prdata = (paddr[2] == REG_TABLE_COUNT) ? 32'(table_count_reg) : '0;

    sjt_front #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .s_zero_ends (s_zero_ends),
        .s_table_addr(s_table_addr),
        .s_table_char(s_table_char),
        .table_count (table_count_reg),
        .q_full      (q_full),
        .push_valid  (push_valid),
        .push_cmd    (push_cmd)
    );

    sjt_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_valid(pop_valid),
        .pop_cmd  (pop_cmd)
    );

    sjt_back #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (pop_valid),
        .q_cmd       (pop_cmd),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_kind  (m_out_kind),
        .m_out_value (m_out_value),
        .m_out_last  (m_out_last),
        .m_any_mapped(m_any_mapped)
    );

endmodule

### verif/sjis_tunnel_char_remapper_tb.sv
`timescale 1ns / 1ps

module sjis_tunnel_char_remapper_tb import sjt_pkg::*;;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_PHASES    = 7;

    typedef struct packed {
        logic                    req;
        logic [BYTE_W-1:0]       b;
        logic                    last;
        logic                    zend;
        logic [TABLE_ADDR_W-1:0] addr;
        logic [CHAR_W-1:0]       ch;
    } beat_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] value;
        logic              last;
        logic              any;
    } res_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        beat_t              bt;
        logic [COUNT_W-1:0] cfg;
        int                 nexp;
        res_t               e0;
        res_t               e1;
    } row_t;

    localparam res_t NO_RES = '0;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_req_type = REQ_BYTE;
    logic [BYTE_W-1:0]       s_data_byte = '0;
    logic                    s_last_byte = 1'b0;
    logic                    s_zero_ends = 1'b0;
    logic [TABLE_ADDR_W-1:0] s_table_addr = '0;
    logic [CHAR_W-1:0]       s_table_char = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [KIND_W-1:0]       m_out_kind;
    logic [CHAR_W-1:0]       m_out_value;
    logic                    m_out_last;
    logic                    m_any_mapped;

    // Shadow of the block: character table, table_count and scan state.
    logic [CHAR_W-1:0]  char_mem [TABLE_DEPTH_DEF];
    bit                 char_known [TABLE_DEPTH_DEF];
    logic [COUNT_W-1:0] tbl_count = '0;
    logic [BYTE_W-1:0]  held_byte = '0;
    bit                 lead_held = 1'b0;
    bit                 mapped_any = 1'b0;
    bit                 skip_rest = 1'b0;

    res_t predicted[$];
    res_t pending_results[$];
    row_t plan[$];

    int mismatches = 0;
    int useful_beats = 0;
    int writes_sent = 0;
    int bytes_sent = 0;
    int cfg_writes = 0;
    int results_seen = 0;
    int raw_seen = 0;
    int map_seen = 0;
    int end_seen = 0;
    int stall_cycles = 0;
    bit held_off = 1'b0;

    always #10 aclk = ~aclk;

    sjis_tunnel_char_remapper i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_data_byte  (s_data_byte),
        .s_last_byte  (s_last_byte),
        .s_zero_ends  (s_zero_ends),
        .s_table_addr (s_table_addr),
        .s_table_char (s_table_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_kind   (m_out_kind),
        .m_out_value  (m_out_value),
        .m_out_last   (m_out_last),
        .m_any_mapped (m_any_mapped)
    );

    task automatic report(input string what);
        mismatches++;
        if (mismatches <= 100) begin
            $display("%0t: mismatch: %s", $time, what);
        end
    endtask

    function automatic res_t mk_res(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] value,
                                    input logic last, input logic any);
        res_t r;
        r.kind = kind;
        r.value = value;
        r.last = last;
        r.any = any;
        return r;
    endfunction

    function automatic beat_t table_beat(input logic [TABLE_ADDR_W-1:0] addr,
                                         input logic [CHAR_W-1:0] ch);
        beat_t bt;
        bt.req = REQ_WRITE;
        bt.b = BYTE_W'($urandom);
        bt.last = 1'($urandom);
        bt.zend = 1'($urandom);
        bt.addr = addr;
        bt.ch = ch;
        return bt;
    endfunction

    function automatic beat_t text_beat(input logic [BYTE_W-1:0] b, input logic last,
                                        input logic zend);
        beat_t bt;
        bt.req = REQ_BYTE;
        bt.b = b;
        bt.last = last;
        bt.zend = zend;
        bt.addr = TABLE_ADDR_W'($urandom);
        bt.ch = CHAR_W'($urandom);
        return bt;
    endfunction

    function automatic logic is_lead(input logic [BYTE_W-1:0] b);
        return (b >= LEAD_A_LO && b < LEAD_A_END) || (b >= LEAD_B_LO && b < LEAD_B_END);
    endfunction

    function automatic logic remap_index(input logic [BYTE_W-1:0] lead,
                                         input logic [BYTE_W-1:0] trail,
                                         output logic [TABLE_ADDR_W-1:0] idx);
        int t;
        idx = '0;
        if (lead < REMAP_LO || lead > REMAP_HI) return 1'b0;
        if (trail < TRAIL_LO || trail > TRAIL_HI || trail == TRAIL_GAP) return 1'b0;
        t = (trail < TRAIL_GAP) ? int'(trail) - int'(TRAIL_LO) : int'(trail) - int'(TRAIL_LO_HI);
        idx = TABLE_ADDR_W'((int'(lead) - int'(REMAP_LO)) * int'(ROW_STRIDE) + t);
        return 1'b1;
    endfunction

    function automatic void remap_predict(input beat_t bt);
        logic [TABLE_ADDR_W-1:0] idx;
        res_t r;
        if (bt.req == REQ_WRITE) begin
            char_mem[bt.addr] = bt.ch;
            char_known[bt.addr] = 1'b1;
            return;
        end
        if (skip_rest) begin
            if (bt.last) skip_rest = 1'b0;
            return;
        end
        if (bt.b == '0 && bt.zend) begin
            predicted.insert(predicted.size(), mk_res(KIND_END, '0, 1'b1, mapped_any));
            lead_held = 1'b0;
            held_byte = '0;
            mapped_any = 1'b0;
            skip_rest = !bt.last;
            return;
        end
        if (lead_held) begin
            lead_held = 1'b0;
            if (remap_index(held_byte, bt.b, idx) && idx < tbl_count) begin
                predicted.insert(predicted.size(), mk_res(KIND_MAP, char_mem[idx], 1'b0, 1'b0));
                mapped_any = 1'b1;
            end else begin
                predicted.insert(predicted.size(),
                                 mk_res(KIND_RAW, CHAR_W'(held_byte), 1'b0, 1'b0));
                predicted.insert(predicted.size(), mk_res(KIND_RAW, CHAR_W'(bt.b), 1'b0, 1'b0));
            end
            held_byte = '0;
        end else if (is_lead(bt.b) && !bt.last) begin
            held_byte = bt.b;
            lead_held = 1'b1;
            return;
        end else begin
            predicted.insert(predicted.size(), mk_res(KIND_RAW, CHAR_W'(bt.b), 1'b0, 1'b0));
        end
        if (bt.last) begin
            r = predicted[predicted.size() - 1];
            r.last = 1'b1;
            r.any = mapped_any;
            predicted[predicted.size() - 1] = r;
            mapped_any = 1'b0;
        end
    endfunction

    // A negative count means the results come from the predictor.
    task automatic send(input beat_t bt, input int nexp, input res_t e0, input res_t e1);
        bit calm;
        calm = useful_beats >= 400 && useful_beats < 700;
        if (!calm && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= bt.req;
        s_data_byte <= bt.b;
        s_last_byte <= bt.last;
        s_zero_ends <= bt.zend;
        s_table_addr <= bt.addr;
        s_table_char <= bt.ch;
        do @(posedge aclk); while (!s_ready);
        if (bt.req == REQ_WRITE) begin
            writes_sent++;
            useful_beats++;
        end else if (!skip_rest) begin
            bytes_sent++;
            useful_beats++;
        end
        predicted.delete();
        remap_predict(bt);
        if (nexp < 0) begin
            foreach (predicted[i]) pending_results.insert(pending_results.size(), predicted[i]);
        end else begin
            if (nexp > 0) pending_results.insert(pending_results.size(), e0);
            if (nexp > 1) pending_results.insert(pending_results.size(), e1);
        end
    endtask

    // Table entries that a pair is about to read get written first, unless already written.
    task automatic send_text(input logic [BYTE_W-1:0] b, input logic last, input logic zend);
        logic [TABLE_ADDR_W-1:0] idx;
        if (!skip_rest && lead_held && !(b == '0 && zend) &&
            remap_index(held_byte, b, idx) && idx < tbl_count && !char_known[idx]) begin
            send(table_beat(idx, CHAR_W'($urandom)), -1, NO_RES, NO_RES);
        end
        send(text_beat(b, last, zend), -1, NO_RES, NO_RES);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [COUNT_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(REG_TABLE_COUNT) << 2;
        pwdata <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tbl_count = v;
        cfg_writes++;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== 32'(v)) begin
            report($sformatf("table_count reads back %h, written %h", prdata, v));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] pick_trail();
        logic [BYTE_W-1:0] v;
        if ($urandom_range(0, 99) < 80) begin
            do v = BYTE_W'($urandom_range(TRAIL_LO, TRAIL_HI)); while (v == TRAIL_GAP);
        end else begin
            v = BYTE_W'($urandom_range(0, 255));
        end
        return v;
    endfunction

    task automatic gen_string();
        logic [BYTE_W-1:0] s[$];
        int len;
        int r;
        logic zend;
        len = $urandom_range(1, 10);
        zend = 1'($urandom_range(0, 1));
        while (s.size() < len) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                s.insert(s.size(), BYTE_W'($urandom_range(REMAP_LO, REMAP_HI)));
                s.insert(s.size(), pick_trail());
            end else if (r < 40) begin
                s.insert(s.size(), BYTE_W'($urandom_range(LEAD_A_LO, LEAD_A_END - 1)));
                s.insert(s.size(), pick_trail());
            end else if (r < 45) begin
                s.insert(s.size(), BYTE_W'($urandom_range(LEAD_B_LO, REMAP_LO - 1)));
                s.insert(s.size(), pick_trail());
            end else if (r < 50) begin
                s.insert(s.size(), BYTE_W'(0));
            end else if (r < 80) begin
                s.insert(s.size(), BYTE_W'($urandom_range(8'h20, 8'h7E)));
            end else begin
                s.insert(s.size(), BYTE_W'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            s.insert(s.size(), BYTE_W'($urandom_range(REMAP_LO, REMAP_HI)));
        end
        foreach (s[i]) begin
            if ($urandom_range(0, 99) < 3) begin
                send(table_beat(TABLE_ADDR_W'($urandom), CHAR_W'($urandom)), -1, NO_RES, NO_RES);
            end
            send_text(s[i], i == s.size() - 1, zend);
        end
    endtask

    task automatic add_beat(input beat_t bt, input int nexp, input res_t e0, input res_t e1);
        row_t row;
        row.kind = ROW_BEAT;
        row.bt = bt;
        row.cfg = '0;
        row.nexp = nexp;
        row.e0 = e0;
        row.e1 = e1;
        plan.insert(plan.size(), row);
    endtask

    task automatic add_cfg(input logic [COUNT_W-1:0] v);
        row_t row;
        row.kind = ROW_CFG;
        row.bt = '0;
        row.cfg = v;
        row.nexp = 0;
        row.e0 = NO_RES;
        row.e1 = NO_RES;
        plan.insert(plan.size(), row);
    endtask

    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_out_kind == KIND_RAW) raw_seen++;
            if (m_out_kind == KIND_MAP) map_seen++;
            if (m_out_kind == KIND_END) end_seen++;
            if (pending_results.size() == 0) begin
                report($sformatf("result kind %0d value %h with nothing outstanding",
                                 m_out_kind, m_out_value));
            end else begin
                want = pending_results.pop_front();
                if (m_out_kind !== want.kind)
                    report($sformatf("out_kind %0d, wanted %0d", m_out_kind, want.kind));
                if (m_out_value !== want.value)
                    report($sformatf("out_value %h, wanted %h", m_out_value, want.value));
                if (m_out_last !== want.last)
                    report($sformatf("out_last %b, wanted %b", m_out_last, want.last));
                if (m_any_mapped !== want.any)
                    report($sformatf("any_mapped %b, wanted %b", m_any_mapped, want.any));
            end
        end
    end

    initial begin : receiver
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (!held_off && results_seen >= 300) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= (results_seen >= 800 && results_seen < 1100) ||
                           $urandom_range(0, 99) >= 6;
            end
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("sjis_tunnel_char_remapper_tb failed");
        $finish;
    end

    initial begin : stimulus
        row_t row;
        int phase_counts [NUM_PHASES];
        int phase_start;

        // Empty table after reset: everything passes raw.
        add_beat(text_beat(8'h41, 1'b1, 1'b0), 1, mk_res(KIND_RAW, 16'h0041, 1'b1, 1'b0), NO_RES);
        add_beat(text_beat(8'h00, 1'b1, 1'b0), 1, mk_res(KIND_RAW, 16'h0000, 1'b1, 1'b0), NO_RES);
        add_beat(text_beat(8'hFF, 1'b1, 1'b1), 1, mk_res(KIND_RAW, 16'h00FF, 1'b1, 1'b0), NO_RES);
        add_beat(table_beat(12'd0, 16'hBEEF), 0, NO_RES, NO_RES);
        add_beat(text_beat(8'hF0, 1'b0, 1'b0), 0, NO_RES, NO_RES);
        add_beat(text_beat(8'h40, 1'b1, 1'b0), 2, mk_res(KIND_RAW, 16'h00F0, 1'b0, 1'b0),
                 mk_res(KIND_RAW, 16'h0040, 1'b1, 1'b0));
        add_cfg(13'd4096);
        add_beat(table_beat(12'd2443, 16'hFFFF), 0, NO_RES, NO_RES);
        add_beat(text_beat(8'hF0, 1'b0, 1'b0), 0, NO_RES, NO_RES);
        add_beat(text_beat(8'h40, 1'b1, 1'b0), 1, mk_res(KIND_MAP, 16'hBEEF, 1'b1, 1'b1), NO_RES);
        add_beat(text_beat(8'hFC, 1'b0, 1'b0), 0, NO_RES, NO_RES);
        add_beat(text_beat(8'hFC, 1'b1, 1'b0), 1, mk_res(KIND_MAP, 16'hFFFF, 1'b1, 1'b1), NO_RES);
        add_beat(text_beat(8'hF0, 1'b0, 1'b0), 0, NO_RES, NO_RES);
        add_beat(text_beat(8'h7F, 1'b0, 1'b0), 2, mk_res(KIND_RAW, 16'h00F0, 1'b0, 1'b0),
                 mk_res(KIND_RAW, 16'h007F, 1'b0, 1'b0));
        add_beat(text_beat(8'hEF, 1'b0, 1'b0), 0, NO_RES, NO_RES);
        add_beat(text_beat(8'h40, 1'b0, 1'b0), 2, mk_res(KIND_RAW, 16'h00EF, 1'b0, 1'b0),
                 mk_res(KIND_RAW, 16'h0040, 1'b0, 1'b0));
        add_beat(text_beat(8'h9F, 1'b1, 1'b0), 1, mk_res(KIND_RAW, 16'h009F, 1'b1, 1'b0), NO_RES);
        add_beat(text_beat(8'hFD, 1'b1, 1'b0), 1, mk_res(KIND_RAW, 16'h00FD, 1'b1, 1'b0), NO_RES);
        // A table write between lead and trail must leave the held lead alone.
        add_beat(text_beat(8'hF0, 1'b0, 1'b1), 0, NO_RES, NO_RES);
        add_beat(table_beat(12'd62, 16'h5A5A), 0, NO_RES, NO_RES);
        add_beat(text_beat(8'h7E, 1'b0, 1'b1), -1, NO_RES, NO_RES);
        add_beat(text_beat(8'hF0, 1'b0, 1'b1), 0, NO_RES, NO_RES);
        add_beat(text_beat(8'h00, 1'b0, 1'b1), 1, mk_res(KIND_END, 16'h0000, 1'b1, 1'b1), NO_RES);
        add_beat(text_beat(8'h41, 1'b0, 1'b1), 0, NO_RES, NO_RES);
        add_beat(text_beat(8'h00, 1'b1, 1'b1), 0, NO_RES, NO_RES);
        add_beat(text_beat(8'h00, 1'b1, 1'b1), 1, mk_res(KIND_END, 16'h0000, 1'b1, 1'b0), NO_RES);
        add_beat(text_beat(8'hA0, 1'b1, 1'b0), 1, mk_res(KIND_RAW, 16'h00A0, 1'b1, 1'b0), NO_RES);

        phase_counts = '{4096, 63, 0, 2444, 188, 0, 4096};
        phase_counts[5] = $urandom_range(0, 4096);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (plan.size() != 0) begin
            row = plan.pop_front();
            if (row.kind == ROW_CFG) begin
                settle();
                cfg_write(row.cfg);
            end else begin
                send(row.bt, row.nexp, row.e0, row.e1);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            cfg_write(COUNT_W'(phase_counts[p]));
            phase_start = useful_beats;
            while (useful_beats - phase_start < RANDOM_ITEMS / NUM_PHASES) begin
                if ($urandom_range(0, 99) < 4) begin
                    send(table_beat(TABLE_ADDR_W'($urandom), CHAR_W'($urandom)), -1,
                         NO_RES, NO_RES);
                end else begin
                    gen_string();
                end
            end
        end

        settle();
        $display("covered %0d table writes and %0d string bytes over %0d table_count settings",
                 writes_sent, bytes_sent, cfg_writes);
        $display("checked %0d raw bytes, %0d mapped characters and %0d end marks",
                 raw_seen, map_seen, end_seen);
        if (mismatches == 0) begin
            $display("sjis_tunnel_char_remapper_tb passed");
        end else begin
            $display("sjis_tunnel_char_remapper_tb failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/sjt_pkg.sv
hdl/sjt_ram.sv
hdl/sjt_front.sv
hdl/sjt_fifo.sv
hdl/sjt_back.sv
hdl/sjis_tunnel_char_remapper.sv
verif/sjis_tunnel_char_remapper_tb.sv
